### sv/gkr_pkg.sv
// shared types and constants for the greedy knapsack by ratio block
package gkr_pkg;

  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned NUMBER_W = 6;
  localparam int unsigned VTOT_W   = 21;
  localparam logic [VTOT_W-1:0] VTOT_MAX = {VTOT_W{1'b1}};

  // configuration register indexes
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [WEIGHT_W-1:0] item_weight;
    logic [VALUE_W-1:0]  item_value;
    logic                last_item;
  } item_t;

  typedef struct packed {
    logic [NUMBER_W-1:0] item_number;
    logic [WEIGHT_W-1:0] taken_weight;
    logic [VALUE_W-1:0]  taken_value;
    logic                item_valid;
    logic [WEIGHT_W-1:0] weight_total;
    logic [VTOT_W-1:0]   value_total;
    logic                overflow;
    logic                last_result;
  } result_t;

  // outcome of one ratio compare
  typedef struct packed {
    logic less;
    logic differs;
  } cmp_t;

endpackage

### sv/gkr_store.sv
// item store: one write port, one read port, registered read data
module gkr_store #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned DATA_W = 38
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data appears in the cycle after the address
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/gkr_ratio.sv
// exact value per weight compare by cross products
module gkr_ratio (
  input  logic [gkr_pkg::WEIGHT_W-1:0] a_weight,
  input  logic [gkr_pkg::VALUE_W-1:0]  a_value,
  input  logic [gkr_pkg::WEIGHT_W-1:0] b_weight,
  input  logic [gkr_pkg::VALUE_W-1:0]  b_value,
  output gkr_pkg::cmp_t                cmp
);
  import gkr_pkg::*;

  logic [WEIGHT_W+VALUE_W-1:0] lhs;
  logic [WEIGHT_W+VALUE_W-1:0] rhs;

  // a.v * b.w against b.v * a.w
  assign lhs = a_value * b_weight;
  assign rhs = b_value * a_weight;
  assign cmp.less    = lhs < rhs;
  assign cmp.differs = lhs != rhs;

endmodule

### sv/greedy_knapsack_by_ratio_core.sv
// top level: item loading, selection sort over the store, greedy walk
//
//  channel   handshake          payload
//  input     start / busy       item   (item_t)
//  output    strobe             result (result_t)
//  config    apb write/read     capacity at byte address 0
//
// a non-final item is stored when it is accepted. the final item starts a run: the
// selection sort reads the unsorted part of the store in each outer step and swaps
// only where the ratios differ, then the walk reads the items from the highest ratio
// down, both bound by the single read port of the item store. busy is high for the
// whole run. reset clears the count, the overflow flag and capacity; the store needs
// no clearing. results appear for one cycle each on strobe and cannot be held off.
module greedy_knapsack_by_ratio_core #(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  gkr_pkg::item_t   item,
  output logic             strobe,
  output gkr_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import gkr_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned ENT_W = WEIGHT_W + VALUE_W + CNT_W;
  localparam int unsigned V_LO  = WEIGHT_W;
  localparam int unsigned N_LO  = WEIGHT_W + VALUE_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_A_RD   = 4'd1;
  localparam logic [3:0] S_A_DAT  = 4'd2;
  localparam logic [3:0] S_B_DAT  = 4'd3;
  localparam logic [3:0] S_SWAP1  = 4'd4;
  localparam logic [3:0] S_SWAP2  = 4'd5;
  localparam logic [3:0] S_W_RD   = 4'd6;
  localparam logic [3:0] S_W_DAT  = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0]          state;
  logic [WEIGHT_W-1:0] capacity;
  logic [CNT_W-1:0]    count;
  logic                overflow_seen;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    a;
  logic [CNT_W-1:0]    b;
  logic [CNT_W-1:0]    kk;
  logic [CNT_W-1:0]    low_idx;
  logic [ENT_W-1:0]    a_ent;
  logic [ENT_W-1:0]    low_ent;
  logic [ENT_W-1:0]    pend;
  logic                pend_valid;
  logic [WEIGHT_W-1:0] wtot;
  logic [VTOT_W-1:0]   vtot;

  logic                accept;
  logic                has_room;
  logic [CNT_W-1:0]    count_next;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [ENT_W-1:0]    wdata;
  logic [IDX_W-1:0]    raddr;
  logic [ENT_W-1:0]    q;
  logic [ENT_W-1:0]    cmp_a;
  cmp_t                cmp;
  logic                next_a_more;
  logic                fits;
  logic [VTOT_W:0]     vsum;
  logic                cfg_write;

  assign busy     = state != S_IDLE;
  assign accept   = start && !busy;
  assign has_room = count < CNT_W'(MAX_ITEMS);
  assign count_next = has_room ? count + 1'b1 : count;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_CAPACITY) ? {16'd0, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_write && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[WEIGHT_W-1:0];
    end
  end

  // store write port: loading and swaps
  always_comb begin
    we    = 1'b0;
    waddr = count[IDX_W-1:0];
    wdata = {count + 1'b1, item.item_value, item.item_weight};
    unique case (state)
      S_IDLE: begin
        we = accept && has_room;
      end
      S_SWAP1: begin
        we    = cmp.differs;
        waddr = a[IDX_W-1:0];
        wdata = low_ent;
      end
      S_SWAP2: begin
        we    = 1'b1;
        waddr = low_idx[IDX_W-1:0];
        wdata = a_ent;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // store read address for the next data cycle
  always_comb begin
    unique case (state)
      S_A_RD:  raddr = a[IDX_W-1:0];
      S_A_DAT: raddr = IDX_W'(a + 1'b1);
      S_B_DAT: raddr = IDX_W'(b + 1'b1);
      S_W_RD:  raddr = kk[IDX_W-1:0];
      S_W_DAT: raddr = IDX_W'(kk - 1'b1);
      default: raddr = '0;
    endcase
  end

  gkr_store #(
    .DEPTH  (MAX_ITEMS),
    .DATA_W (ENT_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (q)
  );

  // shared compare: candidate against current low, or a against low for the swap
  assign cmp_a = (state == S_SWAP1) ? a_ent : q;

  gkr_ratio u_ratio (
    .a_weight (cmp_a[WEIGHT_W-1:0]),
    .a_value  (cmp_a[N_LO-1:V_LO]),
    .b_weight (low_ent[WEIGHT_W-1:0]),
    .b_value  (low_ent[N_LO-1:V_LO]),
    .cmp      (cmp)
  );

  assign next_a_more = ({1'b0, a} + (CNT_W+1)'(2)) < {1'b0, cnt};

  // greedy fit and saturating value sum
  assign fits = ({1'b0, wtot} + {1'b0, q[WEIGHT_W-1:0]}) <= {1'b0, capacity};
  assign vsum = {1'b0, vtot} + (VTOT_W+1)'(q[N_LO-1:V_LO]);

  // sequencer and datapath
  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      overflow_seen <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count <= count_next;
            if (!has_room) begin
              overflow_seen <= 1'b1;
            end
            if (item.last_item) begin
              cnt <= count_next;
              a   <= '0;
              if (count_next >= CNT_W'(2)) begin
                state <= S_A_RD;
              end else begin
                kk         <= count_next - 1'b1;
                wtot       <= '0;
                vtot       <= '0;
                pend_valid <= 1'b0;
                state      <= S_W_RD;
              end
            end
          end
        end
        S_A_RD: begin
          state <= S_A_DAT;
        end
        S_A_DAT: begin
          a_ent   <= q;
          low_ent <= q;
          low_idx <= a;
          b       <= a + 1'b1;
          state   <= S_B_DAT;
        end
        S_B_DAT: begin
          if (cmp.less) begin
            low_ent <= q;
            low_idx <= b;
          end
          if (({1'b0, b} + 1'b1) < {1'b0, cnt}) begin
            b <= b + 1'b1;
          end else begin
            state <= S_SWAP1;
          end
        end
        S_SWAP1, S_SWAP2: begin
          if (state == S_SWAP1 && cmp.differs) begin
            state <= S_SWAP2;
          end else begin
            a <= a + 1'b1;
            if (next_a_more) begin
              state <= S_A_RD;
            end else begin
              kk         <= cnt - 1'b1;
              wtot       <= '0;
              vtot       <= '0;
              pend_valid <= 1'b0;
              state      <= S_W_RD;
            end
          end
        end
        S_W_RD: begin
          state <= S_W_DAT;
        end
        S_W_DAT: begin
          // a taken item releases the one held before it
          if (fits) begin
            wtot       <= wtot + q[WEIGHT_W-1:0];
            vtot       <= (vsum > {1'b0, VTOT_MAX}) ? VTOT_MAX : vsum[VTOT_W-1:0];
            pend       <= q;
            pend_valid <= 1'b1;
            if (pend_valid) begin
              strobe              <= 1'b1;
              result.item_number  <= NUMBER_W'(pend[ENT_W-1:N_LO]);
              result.taken_weight <= pend[WEIGHT_W-1:0];
              result.taken_value  <= pend[N_LO-1:V_LO];
              result.item_valid   <= 1'b1;
              result.weight_total <= '0;
              result.value_total  <= '0;
              result.overflow     <= overflow_seen;
              result.last_result  <= 1'b0;
            end
          end
          if (kk == '0) begin
            state <= S_FINISH;
          end else begin
            kk <= kk - 1'b1;
          end
        end
        S_FINISH: begin
          strobe              <= 1'b1;
          result.item_number  <= pend_valid ? NUMBER_W'(pend[ENT_W-1:N_LO]) : '0;
          result.taken_weight <= pend_valid ? pend[WEIGHT_W-1:0] : '0;
          result.taken_value  <= pend_valid ? pend[N_LO-1:V_LO] : '0;
          result.item_valid   <= pend_valid;
          result.weight_total <= wtot;
          result.value_total  <= vtot;
          result.overflow     <= overflow_seen;
          result.last_result  <= 1'b1;
          count               <= '0;
          overflow_seen       <= 1'b0;
          pend_valid          <= 1'b0;
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // the final result hands the block back to the loader
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_result |-> !busy)
    else $error("final result while still busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond store depth");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.item_valid |-> result.last_result)
    else $error("empty result before the end of a run");

  a_totals_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_result |-> result.weight_total == '0 && result.value_total == '0)
    else $error("totals on a non-final result");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_result |-> count == '0 && !overflow_seen)
    else $error("set state not cleared after a run");
`endif

endmodule

### sim/greedy_knapsack_by_ratio_core_tb.sv
// testbench for the greedy knapsack by ratio block: predicted results checked in order
module greedy_knapsack_by_ratio_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gkr_pkg::*;

  localparam int NITEMS = 32;

  // scoreboard: knapsack model plus queue of pending results
  class knapsack_board;
    logic [15:0] w_store [NITEMS];
    logic [15:0] v_store [NITEMS];
    logic [5:0]  n_store [NITEMS];
    int          count;
    bit          ovf;
    logic [15:0] cap;
    result_t     pending [$];
    int          errors;

    function void clear();
      count = 0;
      ovf = 0;
      cap = '0;
      errors = 0;
    endfunction

    // true if ratio of a is strictly below ratio of b
    function bit ratio_below(int a, int b);
      longint unsigned l, r;
      l = longint'(v_store[a]) * longint'(w_store[b]);
      r = longint'(v_store[b]) * longint'(w_store[a]);
      return l < r;
    endfunction

    function void note_item(item_t it);
      int a, b, low, k, nres;
      logic [15:0] tw, tv;
      logic [5:0] tn;
      int unsigned wtot, vtot;
      longint unsigned l, r;
      result_t res;
      if (count < NITEMS) begin
        w_store[count] = it.item_weight;
        v_store[count] = it.item_value;
        n_store[count] = 6'(count + 1);
        count++;
      end else begin
        ovf = 1;
      end
      if (!it.last_item) return;
      // selection sort, ascending, swap only on differing cross products
      for (a = 0; a + 1 < count; a++) begin
        low = a;
        for (b = a + 1; b < count; b++)
          if (ratio_below(b, low)) low = b;
        l = longint'(v_store[a]) * longint'(w_store[low]);
        r = longint'(v_store[low]) * longint'(w_store[a]);
        if (l != r) begin
          tw = w_store[a]; tv = v_store[a]; tn = n_store[a];
          w_store[a] = w_store[low]; v_store[a] = v_store[low]; n_store[a] = n_store[low];
          w_store[low] = tw; v_store[low] = tv; n_store[low] = tn;
        end
      end
      // greedy walk from the highest ratio
      wtot = 0; vtot = 0; nres = 0;
      for (k = count - 1; k >= 0; k--) begin
        if (wtot + w_store[k] <= cap) begin
          wtot += w_store[k];
          vtot = (vtot + v_store[k] > 2097151) ? 2097151 : vtot + v_store[k];
          res = '0;
          res.item_number = n_store[k];
          res.taken_weight = w_store[k];
          res.taken_value = v_store[k];
          res.item_valid = 1'b1;
          res.overflow = ovf;
          pending.push_back(res);
          nres++;
        end
      end
      if (nres == 0) begin
        res = '0;
        res.overflow = ovf;
        pending.push_back(res);
      end
      res = pending.pop_back();
      res.weight_total = wtot[15:0];
      res.value_total = vtot[20:0];
      res.last_result = 1'b1;
      pending.push_back(res);
      count = 0;
      ovf = 0;
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %h actual %h", exp_r, got);
      end
    endfunction
  endclass

  logic clk, rst, start, busy, strobe, psel, penable, pwrite, pready;
  item_t item;
  result_t result;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  knapsack_board board;

  greedy_knapsack_by_ratio_core u_top (
    .clk, .rst, .start, .busy, .item, .strobe, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && strobe) board.check_result(result);
  end

  // gap between transactions; start drops only when the gap is not empty
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // one input transaction, held until accepted; start stays up for a following item
  task automatic send_item(logic [15:0] w, logic [15:0] v, logic last);
    item_t it;
    it.item_weight = w;
    it.item_value = v;
    it.last_item = last;
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(it);
  endtask

  // register write once the block is idle
  task automatic write_capacity(logic [15:0] c);
    start <= 1'b0;
    while (board.pending.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {REG_CAPACITY, 2'b00}; pwdata <= {16'hA5A5, c};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.cap = c;
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic random_set(int n, int wmax);
    int k, extra;
    extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
    for (k = 0; k < n + extra; k++) begin
      send_item(16'($urandom_range(1, wmax)), 16'($urandom_range(0, 65535)),
                k == n + extra - 1);
      idle_gap();
    end
  endtask

  initial begin
    int k, t;
    int caps [4];
    board = new();
    board.clear();
    rst = 1; start = 0; item = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: capacity zero, nothing taken
    send_item(16'd1, 16'd5, 1'b1);
    write_capacity(16'hFFFF);
    send_item(16'hFFFF, 16'hFFFF, 1'b0);
    send_item(16'd1, 16'd0, 1'b0);
    send_item(16'd2, 16'd4, 1'b0);
    send_item(16'd4, 16'd8, 1'b1);       // tie in ratio
    write_capacity(16'd10);
    send_item(16'd3, 16'd9, 1'b0);
    send_item(16'd6, 16'd12, 1'b0);
    send_item(16'd5, 16'd1, 1'b1);       // fit twice then skip
    // overflow, the dropped item marked last
    for (k = 0; k < NITEMS + 1; k++)
      send_item(16'(k % 3 + 1), 16'(k * 7), k == NITEMS);

    // random phases over several capacities
    caps[0] = 16'hFFFF; caps[1] = 0; caps[2] = 1000; caps[3] = 30000;
    for (t = 0; t < 28; t++) begin
      if (t % 4 == 0) write_capacity(16'(t == 0 ? caps[0] : caps[$urandom_range(0, 3)]));
      if ($urandom_range(0, 3) == 0) random_set($urandom_range(1, 3), 65535);
      else random_set($urandom_range(1, 12), ($urandom_range(0, 1)) ? 65535 : 2000);
    end

    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
